// ===== hdl/uvmmn_pkg.sv =====
// Shared constants and controller/datapath interface types for the UV min-max normalizer.
package uvmmn_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned COORD_W        = 16;
  localparam int unsigned NORM_W         = 17;
  localparam int unsigned DIV_STEPS      = 17;
  localparam int unsigned STEP_W         = 5;

  typedef struct packed {
    logic accept;
    logic rd;
    logic div_init_u;
    logic div_init_v;
    logic div_step;
    logic hold_u;
    logic out_load;
    logic clear;
  } uvmmn_cmd_t;

  typedef struct packed {
    logic last;
  } uvmmn_sts_t;

endpackage

// ===== hdl/uv_min_max_normalizer.sv =====
// Top level of the UV min-max normalizer: controller and datapath.
//
// Input channel (in_valid_i/in_ready_o) carries one signed Q8.8 (u,v) pair per
// transaction plus final_point_i. Pairs load in one cycle each into a store of
// MAX_POINTS entries while the per-axis minimum and maximum are tracked; pairs
// arriving with the store full are discarded and flag the set as dropped.
// The transaction with final_point_i set starts output: every stored pair is
// emitted in arrival order on the output channel (out_valid_o/out_ready_i) as
// unsigned Q1.16 values (65536 = 1.0), run_end_o on the last, dropped_o on
// all results of a set that lost pairs. An axis with zero span gives 0.
// Each result is offered after the transaction that starts it (the final input
// or the previous result) passes a store read, a set-up step and 17 restoring
// steps per axis on one shared radix-2 divider, and a result load.
// The input channel is closed from the final transaction until the last
// result of the set is taken. A stalled receiver holds the result register
// and the sequence. Reset empties the set and returns to loading; the store
// needs no clearing.
module uv_min_max_normalizer import uvmmn_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] u_coord_i,
  input  logic signed [COORD_W-1:0] v_coord_i,
  input  logic                      final_point_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [NORM_W-1:0]         u_norm_o,
  output logic [NORM_W-1:0]         v_norm_o,
  output logic                      run_end_o,
  output logic                      dropped_o
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  uvmmn_cmd_t    cmd;
  uvmmn_sts_t    sts;
  logic [AW-1:0] rd_idx;

  uvmmn_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .final_point_i (final_point_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .rd_idx_o      (rd_idx)
  );

  uvmmn_dp #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW),
    .CW         (CW)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_idx_i  (rd_idx),
    .u_coord_i (u_coord_i),
    .v_coord_i (v_coord_i),
    .sts_o     (sts),
    .u_norm_o  (u_norm_o),
    .v_norm_o  (v_norm_o),
    .run_end_o (run_end_o),
    .dropped_o (dropped_o)
  );

endmodule

// ===== hdl/uvmmn_dp.sv =====
// Datapath: point store, running extremes, shared radix-2 divider and result registers.
module uvmmn_dp import uvmmn_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  parameter int unsigned CW = $clog2(MAX_POINTS + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  uvmmn_cmd_t                cmd_i,
  input  logic [AW-1:0]             rd_idx_i,
  input  logic signed [COORD_W-1:0] u_coord_i,
  input  logic signed [COORD_W-1:0] v_coord_i,
  output uvmmn_sts_t                sts_o,
  output logic [NORM_W-1:0]         u_norm_o,
  output logic [NORM_W-1:0]         v_norm_o,
  output logic                      run_end_o,
  output logic                      dropped_o
);

  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_POINTS);

  logic [2*COORD_W-1:0] mem_q [MAX_POINTS];
  logic [2*COORD_W-1:0] rd_q;

  logic [CW-1:0]             count_q, count_d;
  logic signed [COORD_W-1:0] min_u_q, min_u_d, max_u_q, max_u_d;
  logic signed [COORD_W-1:0] min_v_q, min_v_d, max_v_q, max_v_d;
  logic                      ovf_q, ovf_d;
  logic                      full, store;

  logic [COORD_W:0]   rem_q, rem_d;
  logic [COORD_W-1:0] span_q, span_d;
  logic [NORM_W-1:0]  quo_q, quo_d;
  logic               zero_q, zero_d;
  logic               ge;
  logic [COORD_W:0]   rem_sub;

  logic [NORM_W-1:0] u_hold_q;
  logic [NORM_W-1:0] u_norm_q, v_norm_q;
  logic              run_end_q, dropped_q;

  assign full  = (count_q == FULL_COUNT);
  assign store = cmd_i.accept && !full;

  assign sts_o.last = ((CW'(rd_idx_i) + CW'(1)) == count_q);

  always_ff @(posedge clk_i) begin
    if (store) begin
      mem_q[count_q[AW-1:0]] <= {u_coord_i, v_coord_i};
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[rd_idx_i];
    end
  end

  always_comb begin
    count_d = count_q;
    min_u_d = min_u_q;
    max_u_d = max_u_q;
    min_v_d = min_v_q;
    max_v_d = max_v_q;
    ovf_d   = ovf_q;
    if (cmd_i.clear) begin
      count_d = '0;
      min_u_d = '0;
      max_u_d = '0;
      min_v_d = '0;
      max_v_d = '0;
      ovf_d   = 1'b0;
    end else if (store) begin
      count_d = count_q + CW'(1);
      if (count_q == '0) begin
        min_u_d = u_coord_i;
        max_u_d = u_coord_i;
        min_v_d = v_coord_i;
        max_v_d = v_coord_i;
      end else begin
        if (u_coord_i < min_u_q) min_u_d = u_coord_i;
        if (u_coord_i > max_u_q) max_u_d = u_coord_i;
        if (v_coord_i < min_v_q) min_v_d = v_coord_i;
        if (v_coord_i > max_v_q) max_v_d = v_coord_i;
      end
    end else if (cmd_i.accept) begin
      ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      min_u_q <= '0;
      max_u_q <= '0;
      min_v_q <= '0;
      max_v_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      min_u_q <= min_u_d;
      max_u_q <= max_u_d;
      min_v_q <= min_v_d;
      max_v_q <= max_v_d;
      ovf_q   <= ovf_d;
    end
  end

  assign ge      = (rem_q >= {1'b0, span_q});
  assign rem_sub = ge ? (rem_q - {1'b0, span_q}) : rem_q;

  always_comb begin
    rem_d  = rem_q;
    span_d = span_q;
    quo_d  = quo_q;
    zero_d = zero_q;
    if (cmd_i.div_init_u) begin
      span_d = COORD_W'(max_u_q - min_u_q);
      zero_d = (max_u_q == min_u_q);
      rem_d  = {1'b0, COORD_W'(rd_q[2*COORD_W-1:COORD_W] - min_u_q)};
      quo_d  = '0;
    end else if (cmd_i.div_init_v) begin
      span_d = COORD_W'(max_v_q - min_v_q);
      zero_d = (max_v_q == min_v_q);
      rem_d  = {1'b0, COORD_W'(rd_q[COORD_W-1:0] - min_v_q)};
      quo_d  = '0;
    end else if (cmd_i.div_step) begin
      rem_d = {rem_sub[COORD_W-1:0], 1'b0};
      quo_d = {quo_q[NORM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    span_q <= span_d;
    quo_q  <= quo_d;
    zero_q <= zero_d;
    if (cmd_i.hold_u) begin
      u_hold_q <= zero_q ? '0 : quo_q;
    end
    if (cmd_i.out_load) begin
      u_norm_q  <= u_hold_q;
      v_norm_q  <= zero_q ? '0 : quo_q;
      run_end_q <= sts_o.last;
      dropped_q <= ovf_q;
    end
  end

  assign u_norm_o  = u_norm_q;
  assign v_norm_o  = v_norm_q;
  assign run_end_o = run_end_q;
  assign dropped_o = dropped_q;

endmodule

// ===== hdl/uvmmn_ctrl.sv =====
// Controller: load, per-point divide sequencing and output handshake.
module uvmmn_ctrl import uvmmn_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          final_point_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  uvmmn_sts_t    sts_i,
  output uvmmn_cmd_t    cmd_o,
  output logic [AW-1:0] rd_idx_o
);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_INU  = 3'd2;
  localparam logic [2:0] S_DIVU = 3'd3;
  localparam logic [2:0] S_INV  = 3'd4;
  localparam logic [2:0] S_DIVV = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (final_point_i) begin
            idx_d   = '0;
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_INU;
      end
      S_INU: begin
        cmd_o.div_init_u = 1'b1;
        step_d  = '0;
        state_d = S_DIVU;
      end
      S_DIVU: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + STEP_W'(1);
        if (step_q == LAST_STEP) state_d = S_INV;
      end
      S_INV: begin
        cmd_o.hold_u     = 1'b1;
        cmd_o.div_init_v = 1'b1;
        step_d  = '0;
        state_d = S_DIVV;
      end
      S_DIVV: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + STEP_W'(1);
        if (step_q == LAST_STEP) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.out_load = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.last) begin
            cmd_o.clear = 1'b1;
            state_d     = S_LOAD;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      idx_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
    end
  end

  assign rd_idx_o = idx_q;

endmodule
